// File: hw/rtl/rmlp_pkg.sv
`default_nettype none

package rmlp_pkg;

    // network shape
    localparam int N_IN      = 5;
    localparam int N_HIDDEN  = 15;
    localparam int N_OUT     = 5;
    localparam int N_CARRY   = 6;
    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 8;

    localparam int L0_IN   = N_IN + N_CARRY;
    localparam int L1_OUT  = N_OUT + N_CARRY;
    localparam int W1_BASE = L0_IN * N_HIDDEN;
    localparam int BH_BASE = W1_BASE + N_HIDDEN * L1_OUT;
    localparam int BO_BASE = BH_BASE + N_HIDDEN;

    localparam int STORE_DEPTH = 512;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // leaky relu slope register
    localparam int LEAK_W     = 8;
    localparam int LEAK_SHIFT = 8;
    localparam logic [LEAK_W-1:0] LEAK_RESET = LEAK_W'(26);

    // arithmetic widths
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + 8;

    // counters and indexes
    localparam int MAX_TERMS = (L0_IN > N_HIDDEN) ? L0_IN : N_HIDDEN;
    localparam int NODE_MAX  = (N_HIDDEN > L1_OUT) ? N_HIDDEN : L1_OUT;
    localparam int IDX_W     = $clog2(MAX_TERMS + 1);
    localparam int NODE_W    = (NODE_MAX > 1) ? $clog2(NODE_MAX) : 1;
    localparam int L0_IW     = (L0_IN > 1) ? $clog2(L0_IN) : 1;
    localparam int HID_IW    = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [ADDR_W-1:0]        t_addr;

    // controller to datapath
    typedef struct packed {
        logic              load;
        logic              start;
        logic              seq_start;
        logic              issue;
        logic              is_bias;
        logic              last;
        logic              layer;
        logic [NODE_W-1:0] node;
        logic [IDX_W-1:0]  act_idx;
        t_addr             raddr;
        logic              publish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pipe_empty;
        logic out_busy;
    } t_stat;

    // tag that travels with each term through the mac pipeline
    typedef struct packed {
        logic              v;
        logic              is_bias;
        logic              last;
        logic              layer;
        logic [NODE_W-1:0] node;
        logic [IDX_W-1:0]  act_idx;
    } t_tag;

endpackage

`default_nettype wire

// File: hw/rtl/rmlp_req_if.sv
`default_nettype none

interface rmlp_req_if;
    import rmlp_pkg::*;

    logic         valid;
    logic         ready;
    logic         mode;
    t_addr        param_addr;
    t_data        param_value;
    logic         seq_start;
    t_data        in0;
    t_data        in1;
    t_data        in2;
    t_data        in3;
    t_data        in4;

    modport source (
        output valid, mode, param_addr, param_value, seq_start, in0, in1, in2, in3, in4,
        input  ready
    );
    modport sink (
        input  valid, mode, param_addr, param_value, seq_start, in0, in1, in2, in3, in4,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/rmlp_res_if.sv
`default_nettype none

interface rmlp_res_if;
    import rmlp_pkg::*;

    logic  valid;
    logic  ready;
    t_data out0;
    t_data out1;
    t_data out2;
    t_data out3;
    t_data out4;

    modport source (
        output valid, out0, out1, out2, out3, out4,
        input  ready
    );
    modport sink (
        input  valid, out0, out1, out2, out3, out4,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/rmlp_cfg_if.sv
`default_nettype none

interface rmlp_cfg_if;
    import rmlp_pkg::*;

    logic              valid;
    logic              ready;
    logic [LEAK_W-1:0] leak_slope;

    modport source (
        output valid, leak_slope,
        input  ready
    );
    modport sink (
        input  valid, leak_slope,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/rmlp_ram.sv
`default_nettype none

module rmlp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/rmlp_ctrl.sv
`default_nettype none

module rmlp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    input  wire logic           i_req_mode,
    input  wire logic           i_req_seq_start,
    input  wire rmlp_pkg::t_stat i_stat,
    output logic                o_req_ready,
    output rmlp_pkg::t_cmd      o_cmd
);
    import rmlp_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic              r_layer, n_layer;
    logic [NODE_W-1:0] r_node, n_node;
    logic [IDX_W-1:0]  r_term, n_term;
    t_addr             r_wptr, n_wptr;

    logic              w_accept;
    logic [IDX_W-1:0]  w_term_last;
    logic [NODE_W-1:0] w_node_last;
    t_addr             w_bias_addr;
    t_addr             w_wbase;
    t_addr             w_stride;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;

    assign w_term_last = r_layer ? IDX_W'(N_HIDDEN) : IDX_W'(L0_IN);
    assign w_node_last = r_layer ? NODE_W'(L1_OUT - 1) : NODE_W'(N_HIDDEN - 1);
    assign w_bias_addr = (r_layer ? ADDR_W'(BO_BASE) : ADDR_W'(BH_BASE)) + ADDR_W'(r_node);
    assign w_wbase     = r_layer ? ADDR_W'(W1_BASE) : '0;
    assign w_stride    = r_layer ? ADDR_W'(L1_OUT) : ADDR_W'(N_HIDDEN);

    always_comb begin
        n_state = r_state;
        n_layer = r_layer;
        n_node  = r_node;
        n_term  = r_term;
        n_wptr  = r_wptr;

        o_cmd           = '0;
        o_cmd.load      = w_accept && !i_req_mode;
        o_cmd.start     = w_accept && i_req_mode;
        o_cmd.seq_start = i_req_seq_start;
        o_cmd.layer     = r_layer;
        o_cmd.node      = r_node;
        o_cmd.act_idx   = IDX_W'(r_term - 1'b1);
        o_cmd.is_bias   = (r_term == '0);
        o_cmd.last      = (r_term == w_term_last);
        o_cmd.raddr     = o_cmd.is_bias ? w_bias_addr : r_wptr;

        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_state = S_RUN;
                    n_layer = 1'b0;
                    n_node  = '0;
                    n_term  = '0;
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                // bias first, then walk the weight column with the layer stride
                n_wptr = o_cmd.is_bias ? (w_wbase + ADDR_W'(r_node)) : (r_wptr + w_stride);
                if (o_cmd.last) begin
                    n_term = '0;
                    if (r_node == w_node_last) begin
                        n_node = '0;
                        if (r_layer) begin
                            n_state = S_DRAIN;
                        end else begin
                            n_layer = 1'b1;
                        end
                    end else begin
                        n_node = NODE_W'(r_node + 1'b1);
                    end
                end else begin
                    n_term = IDX_W'(r_term + 1'b1);
                end
            end
            S_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_layer <= 1'b0;
            r_node  <= '0;
            r_term  <= '0;
        end else begin
            r_state <= n_state;
            r_layer <= n_layer;
            r_node  <= n_node;
            r_term  <= n_term;
        end
        r_wptr <= n_wptr;
    end

    // the final term of the output layer ends the issue phase
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.issue && o_cmd.last && r_layer && (r_node == w_node_last))
        |=> (r_state == S_DRAIN))
        else $error("issue phase did not end after last output node");

    // a result is published only once the mac pipeline has drained
    a_publish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> i_stat.pipe_empty)
        else $error("publish with terms still in flight");

endmodule

`default_nettype wire

// File: hw/rtl/rmlp_dp.sv
`default_nettype none

module rmlp_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rmlp_pkg::t_cmd                i_cmd,
    input  wire rmlp_pkg::t_addr               i_param_addr,
    input  wire rmlp_pkg::t_data               i_param_value,
    input  wire rmlp_pkg::t_data               i_in [rmlp_pkg::N_IN],
    input  wire logic                          i_cfg_valid,
    input  wire logic [rmlp_pkg::LEAK_W-1:0]   i_cfg_leak,
    input  wire rmlp_pkg::t_data               i_ram_rdata,
    input  wire logic                          i_out_ready,
    output logic                               o_ram_we,
    output rmlp_pkg::t_addr                    o_ram_waddr,
    output rmlp_pkg::t_data                    o_ram_wdata,
    output rmlp_pkg::t_stat                    o_stat,
    output logic                               o_out_valid,
    output rmlp_pkg::t_data                    o_out [rmlp_pkg::N_OUT]
);
    import rmlp_pkg::*;

    logic [LEAK_W-1:0] r_leak;
    t_data             r_in     [N_IN];
    t_data             r_carry  [N_CARRY];
    t_data             r_hidden [N_HIDDEN];
    t_data             r_res    [N_OUT];
    t_data             r_out    [N_OUT];
    logic              r_out_valid;

    t_tag                      r_s1, r_s2, r_s3, r_s4;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    t_data                     r_sat;

    t_data                        w_act0 [L0_IN];
    t_data                        w_act;
    logic signed [PROD_W-1:0]     w_mul;
    logic signed [PROD_W-1:0]     w_bias;
    logic signed [ACC_W-1:0]      w_shift;
    logic [ACC_W-DATA_W:0]        w_hi;
    t_data                        w_sat;
    logic signed [DATA_W+LEAK_W:0] w_lkp;
    logic signed [DATA_W+LEAK_W:0] w_lks;
    t_data                        w_relu;

    // parameter loads go straight to the store
    assign o_ram_we    = i_cmd.load;
    assign o_ram_waddr = i_param_addr;
    assign o_ram_wdata = i_param_value;

    // layer-0 activation vector: samples then carries
    for (genvar k = 0; k < L0_IN; k++) begin : g_act0
        if (k < N_IN) begin : g_smp
            assign w_act0[k] = r_in[k];
        end else begin : g_car
            assign w_act0[k] = r_carry[k - N_IN];
        end
    end

    // stage 1: weight times activation, or bias aligned to the product scale
    assign w_act  = r_s1.layer ? r_hidden[r_s1.act_idx[HID_IW-1:0]]
                               : w_act0[r_s1.act_idx[L0_IW-1:0]];
    assign w_mul  = i_ram_rdata * w_act;
    assign w_bias = PROD_W'(i_ram_rdata) <<< FRAC_BITS;

    // stage 3: floor shift and saturate
    assign w_shift = r_acc >>> FRAC_BITS;
    assign w_hi    = w_shift[ACC_W-1:DATA_W-1];
    always_comb begin
        if ((&w_hi) || !(|w_hi)) begin
            w_sat = w_shift[DATA_W-1:0];
        end else if (w_shift[ACC_W-1]) begin
            w_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // stage 4: leaky relu
    assign w_lkp  = r_sat * $signed({1'b0, r_leak});
    assign w_lks  = w_lkp >>> LEAK_SHIFT;
    assign w_relu = (!r_sat[DATA_W-1] && (|r_sat)) ? r_sat : w_lks[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leak      <= LEAK_RESET;
            r_out_valid <= 1'b0;
            r_s1.v      <= 1'b0;
            r_s2.v      <= 1'b0;
            r_s3.v      <= 1'b0;
            r_s4.v      <= 1'b0;
            for (int k = 0; k < N_CARRY; k++) begin
                r_carry[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_leak <= i_cfg_leak;
            end

            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            r_s1   <= '{v: i_cmd.issue, is_bias: i_cmd.is_bias, last: i_cmd.last,
                        layer: i_cmd.layer, node: i_cmd.node, act_idx: i_cmd.act_idx};
            r_s2   <= r_s1;
            // only the final term of a node moves on past the accumulator
            r_s3   <= '{v: r_s2.v && r_s2.last, is_bias: r_s2.is_bias, last: r_s2.last,
                        layer: r_s2.layer, node: r_s2.node, act_idx: r_s2.act_idx};
            r_s4   <= r_s3;

            if (i_cmd.start && i_cmd.seq_start) begin
                for (int k = 0; k < N_CARRY; k++) begin
                    r_carry[k] <= '0;
                end
            end else if (r_s4.v && r_s4.layer) begin
                for (int k = 0; k < N_CARRY; k++) begin
                    if (r_s4.node == NODE_W'(N_OUT + k)) begin
                        r_carry[k] <= w_relu;
                    end
                end
            end
        end

        if (i_cmd.start) begin
            r_in <= i_in;
        end
        if (r_s1.v) begin
            r_prod <= r_s1.is_bias ? w_bias : w_mul;
        end
        if (r_s2.v) begin
            r_acc <= r_s2.is_bias ? ACC_W'(r_prod) : (r_acc + ACC_W'(r_prod));
        end
        if (r_s3.v) begin
            r_sat <= w_sat;
        end
        if (r_s4.v) begin
            for (int k = 0; k < N_HIDDEN; k++) begin
                if (!r_s4.layer && (r_s4.node == NODE_W'(k))) begin
                    r_hidden[k] <= w_relu;
                end
            end
            for (int k = 0; k < N_OUT; k++) begin
                if (r_s4.layer && (r_s4.node == NODE_W'(k))) begin
                    r_res[k] <= w_relu;
                end
            end
        end
        if (i_cmd.publish) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;
    assign o_stat.pipe_empty = !(r_s1.v || r_s2.v || r_s3.v || r_s4.v);
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    // a waiting result is never overwritten
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |-> !(r_out_valid && !i_out_ready))
        else $error("result overwritten before it was taken");

    // output layer writeback stays inside the output and carry nodes
    a_wb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4.v && r_s4.layer) |-> (r_s4.node < NODE_W'(L1_OUT)))
        else $error("output layer node out of range");

    // a step starts only with the mac pipeline empty
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> o_stat.pipe_empty)
        else $error("step started with terms in flight");

endmodule

`default_nettype wire

// File: hw/rtl/recurrent_mlp_leaky_relu_inference.sv
`default_nettype none

// channel   modport  handshake             payload
// i_req     sink     valid / ready         mode, param_addr, param_value, seq_start, in0..in4
// o_res     source   valid / ready         out0..out4
// i_cfg     sink     valid / ready (tied)  leak_slope
//
// a load request (mode 0) writes the parameter store
// a step request (mode 1) has one shared mac walk 356 bias and weight terms,
//   one per cycle, bound by the single read port of the parameter store, then
//   drains the four mac stages and the empty check and moves the result into the
//   output register; the next request is taken only after that move, once the
//   controller is back in idle
// reset is synchronous active low; carries clear, leak slope returns to 26, the
//   parameter store holds no reset and must be written before it is read
// a result waiting on o_res does not block loads or the next step; a finished step
//   holds in the controller until the output register is free

module recurrent_mlp_leaky_relu_inference (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rmlp_req_if.sink    i_req,
    rmlp_res_if.source  o_res,
    rmlp_cfg_if.sink    i_cfg
);
    import rmlp_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  req_ready;

    // parameter store wiring
    logic  ram_we;
    t_addr ram_waddr;
    t_data ram_wdata;
    t_data ram_rdata;

    // sample vector and result vector
    t_data req_in  [N_IN];
    t_data res_out [N_OUT];
    logic  res_valid;

    assign req_in[0] = i_req.in0;
    assign req_in[1] = i_req.in1;
    assign req_in[2] = i_req.in2;
    assign req_in[3] = i_req.in3;
    assign req_in[4] = i_req.in4;

    assign i_req.ready = req_ready;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid = res_valid;
    assign o_res.out0  = res_out[0];
    assign o_res.out1  = res_out[1];
    assign o_res.out2  = res_out[2];
    assign o_res.out3  = res_out[3];
    assign o_res.out4  = res_out[4];

    // sequencer: request intake, node and term counters, store addressing
    rmlp_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_req.valid),
        .i_req_mode      (i_req.mode),
        .i_req_seq_start (i_req.seq_start),
        .i_stat          (stat),
        .o_req_ready     (req_ready),
        .o_cmd           (cmd)
    );

    // weights and biases, one write and one registered read per cycle
    rmlp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (cmd.raddr),
        .o_rdata (ram_rdata)
    );

    // mac pipeline, activations, carries and output register
    rmlp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_param_addr  (i_req.param_addr),
        .i_param_value (i_req.param_value),
        .i_in          (req_in),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_leak    (i_cfg.leak_slope),
        .i_ram_rdata   (ram_rdata),
        .i_out_ready   (o_res.ready),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_stat        (stat),
        .o_out_valid   (res_valid),
        .o_out         (res_out)
    );

endmodule

`default_nettype wire
